>>> rtl/lpwq_pkg.sv
`default_nettype none

package lpwq_pkg;

    localparam int CMD_DEPTH  = 128;
    localparam int CHAR_DEPTH = 128;

    localparam int CMD_AW  = $clog2(CMD_DEPTH);
    localparam int CMD_CW  = CMD_AW + 1;
    localparam int CHAR_AW = $clog2(CHAR_DEPTH);
    localparam int CHAR_CW = CHAR_AW + 1;

    localparam logic [CMD_AW-1:0]  CMD_LAST  = CMD_AW'(CMD_DEPTH - 1);
    localparam logic [CMD_CW-1:0]  CMD_FULL  = CMD_CW'(CMD_DEPTH);
    localparam logic [CHAR_AW-1:0] CHAR_LAST = CHAR_AW'(CHAR_DEPTH - 1);
    localparam logic [CHAR_CW-1:0] CHAR_FULL = CHAR_CW'(CHAR_DEPTH);

    localparam int INIT_LEN = 5;
    localparam int INIT_AW  = $clog2(INIT_LEN);
    localparam logic [7:0] INIT_SEQ [INIT_LEN] = '{8'd1, 8'd2, 8'd6, 8'd12, 8'd56};

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int M_USED_W  = 11;

    typedef enum logic [1:0] {
        MODE_TICK      = 2'd0,
        MODE_PUSH_CMD  = 2'd1,
        MODE_PUSH_CHAR = 2'd2
    } mode_t;

endpackage

`default_nettype wire

>>> rtl/lcd_priority_write_queue_top.sv
// Path: a word accepted from s_ is held in an input register, then passes to a result
// register, whose word is valid on m_; m_ back-pressure can hold it in the input register.
// Throughput: one word per cycle unless m_tready low stalls the result register; the
// input and result registers are parted by one pass of FIFO pointer and pin logic.
// Reset (aresetn low, synchronous): the command FIFO holds the five init bytes,
// the character FIFO is empty, all pins are low and the first tick drives E low.
`default_nettype none

module lcd_priority_write_queue_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [7:0] data_byte
    input  wire logic [lpwq_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] mode
    input  wire logic [lpwq_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [0] rs_level, [1] enable_level, [9:2] bus_byte, [10] push_dropped
    output logic [lpwq_pkg::M_TDATA_W-1:0]       m_tdata
);
    import lpwq_pkg::*;

    logic                 in_valid_reg;
    logic [1:0]           in_mode_reg;
    logic [7:0]           in_byte_reg;
    logic                 advance;

    logic [7:0]           cmd_mem [CMD_DEPTH];
    logic [CMD_AW-1:0]    cmd_head_reg, cmd_head_next;
    logic [CMD_AW-1:0]    cmd_tail_reg, cmd_tail_next;
    logic [CMD_CW-1:0]    cmd_count_reg, cmd_count_next;
    logic [7:0]           cmd_rdata_reg;
    logic [INIT_LEN-1:0]  init_pend_reg;
    logic                 cmd_we;

    logic [7:0]           char_mem [CHAR_DEPTH];
    logic [CHAR_AW-1:0]   char_head_reg, char_head_next;
    logic [CHAR_AW-1:0]   char_tail_reg, char_tail_next;
    logic [CHAR_CW-1:0]   char_count_reg, char_count_next;
    logic [7:0]           char_rdata_reg;
    logic                 char_we;

    logic                 phase_reg, phase_next;
    logic                 rs_reg, rs_next;
    logic                 enable_reg, enable_next;
    logic [7:0]           bus_reg, bus_next;
    logic                 dropped;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign advance  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    always_comb begin
        cmd_head_next   = cmd_head_reg;
        cmd_tail_next   = cmd_tail_reg;
        cmd_count_next  = cmd_count_reg;
        char_head_next  = char_head_reg;
        char_tail_next  = char_tail_reg;
        char_count_next = char_count_reg;
        phase_next      = phase_reg;
        rs_next         = rs_reg;
        enable_next     = enable_reg;
        bus_next        = bus_reg;
        dropped         = 1'b0;
        cmd_we          = 1'b0;
        char_we         = 1'b0;
        if (advance) begin
            case (in_mode_reg)
                MODE_PUSH_CMD: begin
                    if (cmd_count_reg == CMD_FULL) begin
                        dropped = 1'b1;
                    end else begin
                        cmd_we         = 1'b1;
                        cmd_tail_next  = (cmd_tail_reg == CMD_LAST) ? '0 : cmd_tail_reg + 1'b1;
                        cmd_count_next = cmd_count_reg + 1'b1;
                    end
                end
                MODE_PUSH_CHAR: begin
                    if (char_count_reg == CHAR_FULL) begin
                        dropped = 1'b1;
                    end else begin
                        char_we         = 1'b1;
                        char_tail_next  = (char_tail_reg == CHAR_LAST) ? '0 : char_tail_reg + 1'b1;
                        char_count_next = char_count_reg + 1'b1;
                    end
                end
                MODE_TICK: begin
                    if (!phase_reg) begin
                        if (cmd_count_reg != '0) begin
                            rs_next        = 1'b0;
                            enable_next    = 1'b1;
                            bus_next       = cmd_rdata_reg;
                            cmd_head_next  = (cmd_head_reg == CMD_LAST) ? '0 : cmd_head_reg + 1'b1;
                            cmd_count_next = cmd_count_reg - 1'b1;
                        end else if (char_count_reg != '0) begin
                            rs_next         = 1'b1;
                            enable_next     = 1'b1;
                            bus_next        = char_rdata_reg;
                            char_head_next  = (char_head_reg == CHAR_LAST) ? '0 :
                                              char_head_reg + 1'b1;
                            char_count_next = char_count_reg - 1'b1;
                        end
                        phase_next = 1'b1;
                    end else begin
                        enable_next = 1'b0;
                        phase_next  = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_head_reg   <= '0;
            cmd_tail_reg   <= CMD_AW'(INIT_LEN);
            cmd_count_reg  <= CMD_CW'(INIT_LEN);
            char_head_reg  <= '0;
            char_tail_reg  <= '0;
            char_count_reg <= '0;
            phase_reg      <= 1'b1;
            rs_reg         <= 1'b0;
            enable_reg     <= 1'b0;
            bus_reg        <= '0;
        end else begin
            cmd_head_reg   <= cmd_head_next;
            cmd_tail_reg   <= cmd_tail_next;
            cmd_count_reg  <= cmd_count_next;
            char_head_reg  <= char_head_next;
            char_tail_reg  <= char_tail_next;
            char_count_reg <= char_count_next;
            phase_reg      <= phase_next;
            rs_reg         <= rs_next;
            enable_reg     <= enable_next;
            bus_reg        <= bus_next;
        end
    end

    // The read port always holds the entry at the head pointer, so a pop needs no wait.
    // Init bytes that have not been overwritten yet come from the constant table.
    always_ff @(posedge aclk) begin
        if (cmd_we) begin
            cmd_mem[cmd_tail_reg] <= in_byte_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_pend_reg <= '1;
            cmd_rdata_reg <= INIT_SEQ[0];
        end else begin
            if (cmd_we && (cmd_tail_reg < CMD_AW'(INIT_LEN))) begin
                init_pend_reg[cmd_tail_reg[INIT_AW-1:0]] <= 1'b0;
            end
            if (cmd_we && (cmd_tail_reg == cmd_head_next)) begin
                cmd_rdata_reg <= in_byte_reg;
            end else if ((cmd_head_next < CMD_AW'(INIT_LEN)) &&
                         init_pend_reg[cmd_head_next[INIT_AW-1:0]]) begin
                cmd_rdata_reg <= INIT_SEQ[cmd_head_next[INIT_AW-1:0]];
            end else begin
                cmd_rdata_reg <= cmd_mem[cmd_head_next];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (char_we) begin
            char_mem[char_tail_reg] <= in_byte_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (char_we && (char_tail_reg == char_head_next)) begin
            char_rdata_reg <= in_byte_reg;
        end else begin
            char_rdata_reg <= char_mem[char_head_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= {{(M_TDATA_W - M_USED_W){1'b0}}, dropped, bus_next,
                            enable_next, rs_next};
        end
    end

endmodule

`default_nettype wire
